>>> rtl/sobel_edge_magnitude_core_assert.svh
// assertion macros used by the checker file
// the enclosing module must provide clk and rst
`ifndef SOBEL_EDGE_MAGNITUDE_CORE_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_CORE_ASSERT_SVH

// same-cycle implication, idle while in reset
`define SEM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, idle while in reset
`define SEM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/sobel_em_pkg.sv
package sobel_em_pkg;

  // frame limits
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  // field and counter widths
  localparam int PIX_W   = 8;
  localparam int SIZE_W  = 13;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int COORD_W = 12;
  localparam int SUM_W   = PIX_W + 2;
  localparam int GRAD_W  = PIX_W + 3;

  // apb port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // size register reset values and limits
  localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);
  localparam logic [SIZE_W-1:0] SIZE_MIN     = SIZE_W'(3);
  localparam logic [SIZE_W-1:0] WIDTH_MAX    = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0] HEIGHT_MAX   = SIZE_W'(MAX_HEIGHT);

  // window reaches two rows and two columns back
  localparam int WIN_SPAN = 2;

  // magnitude saturation
  localparam logic [PIX_W-1:0] MAG_MAX = PIX_W'(255);

  // register word index
  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_t;

  typedef logic [PIX_W-1:0] pixel_t;

  // one window column, top row first
  typedef struct packed {
    pixel_t top;
    pixel_t mid;
    pixel_t bot;
  } column_t;

  // position tag carried with each pixel down the pipeline
  typedef struct packed {
    logic               emit;
    logic               last;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } pos_t;

endpackage

>>> rtl/sobel_em_ram.sv
module sobel_em_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/sobel_em_cfg.sv
module sobel_em_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sobel_em_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [sobel_em_pkg::APB_DATA_W-1:0] pwdata,
  output logic [sobel_em_pkg::APB_DATA_W-1:0] prdata,
  output logic                                pready,
  output logic [sobel_em_pkg::SIZE_W-1:0]     width,
  output logic [sobel_em_pkg::SIZE_W-1:0]     height
);

  logic [sobel_em_pkg::SIZE_W-1:0] image_width;
  logic [sobel_em_pkg::SIZE_W-1:0] image_height;
  sobel_em_pkg::reg_idx_t          sel;
  logic                            wr;

  assign pready = 1'b1;
  assign sel    = sobel_em_pkg::reg_idx_t'(paddr[2]);
  assign wr     = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= sobel_em_pkg::WIDTH_RESET;
      image_height <= sobel_em_pkg::HEIGHT_RESET;
    end else if (wr) begin
      case (sel)
        sobel_em_pkg::REG_IMAGE_WIDTH:  image_width  <= pwdata[sobel_em_pkg::SIZE_W-1:0];
        sobel_em_pkg::REG_IMAGE_HEIGHT: image_height <= pwdata[sobel_em_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (sel)
      sobel_em_pkg::REG_IMAGE_WIDTH:  prdata = sobel_em_pkg::APB_DATA_W'(image_width);
      sobel_em_pkg::REG_IMAGE_HEIGHT: prdata = sobel_em_pkg::APB_DATA_W'(image_height);
      default:                        prdata = '0;
    endcase
  end

  // sizes in use, clamped to the supported range
  always_comb begin
    if (image_width < sobel_em_pkg::SIZE_MIN) begin
      width = sobel_em_pkg::SIZE_MIN;
    end else if (image_width > sobel_em_pkg::WIDTH_MAX) begin
      width = sobel_em_pkg::WIDTH_MAX;
    end else begin
      width = image_width;
    end
    if (image_height < sobel_em_pkg::SIZE_MIN) begin
      height = sobel_em_pkg::SIZE_MIN;
    end else if (image_height > sobel_em_pkg::HEIGHT_MAX) begin
      height = sobel_em_pkg::HEIGHT_MAX;
    end else begin
      height = image_height;
    end
  end

endmodule

>>> rtl/sobel_em_scan.sv
module sobel_em_scan (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             advance,
  input  logic [sobel_em_pkg::SIZE_W-1:0]  width,
  input  logic [sobel_em_pkg::SIZE_W-1:0]  height,
  output logic [sobel_em_pkg::COL_W-1:0]   col_addr,
  output sobel_em_pkg::pos_t               pos
);

  logic [sobel_em_pkg::COL_W-1:0]  col;
  logic [sobel_em_pkg::COL_W-1:0]  col_next;
  logic [sobel_em_pkg::ROW_W-1:0]  row;
  logic [sobel_em_pkg::ROW_W-1:0]  row_next;
  logic [sobel_em_pkg::SIZE_W-1:0] col_ext;
  logic [sobel_em_pkg::SIZE_W-1:0] row_ext;

  assign col_ext  = sobel_em_pkg::SIZE_W'(col);
  assign row_ext  = sobel_em_pkg::SIZE_W'(row);
  assign col_addr = col;

  // raster counters, wrapping at the current size
  always_comb begin
    col_next = col;
    row_next = row;
    if (advance) begin
      if (col_ext + sobel_em_pkg::SIZE_W'(1) >= width) begin
        col_next = '0;
        if (row_ext + sobel_em_pkg::SIZE_W'(1) >= height) begin
          row_next = '0;
        end else begin
          row_next = row + sobel_em_pkg::ROW_W'(1);
        end
      end else begin
        col_next = col + sobel_em_pkg::COL_W'(1);
        if (row_ext >= height) begin
          row_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else begin
      col <= col_next;
      row <= row_next;
    end
  end

  // window position of the pixel at the counters
  always_comb begin
    pos.emit = (row >= sobel_em_pkg::ROW_W'(sobel_em_pkg::WIN_SPAN))
            && (col >= sobel_em_pkg::COL_W'(sobel_em_pkg::WIN_SPAN));
    pos.last = (row_ext == height - sobel_em_pkg::SIZE_W'(1))
            && (col_ext == width - sobel_em_pkg::SIZE_W'(1));
    pos.row  = sobel_em_pkg::COORD_W'(row - sobel_em_pkg::ROW_W'(sobel_em_pkg::WIN_SPAN));
    pos.col  = sobel_em_pkg::COORD_W'(col - sobel_em_pkg::COL_W'(sobel_em_pkg::WIN_SPAN));
  end

endmodule

>>> rtl/sobel_em_kernel.sv
module sobel_em_kernel (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  sobel_em_pkg::pos_t             in_pos,
  input  sobel_em_pkg::column_t          cur,
  output logic                           out_valid,
  output sobel_em_pkg::pos_t             out_pos,
  output logic [sobel_em_pkg::PIX_W-1:0] mag
);

  sobel_em_pkg::column_t                  win0;
  sobel_em_pkg::column_t                  win1;
  logic [sobel_em_pkg::SUM_W-1:0]         gx_pos;
  logic [sobel_em_pkg::SUM_W-1:0]         gx_neg;
  logic [sobel_em_pkg::SUM_W-1:0]         gy_pos;
  logic [sobel_em_pkg::SUM_W-1:0]         gy_neg;
  logic signed [sobel_em_pkg::GRAD_W-1:0] gx_next;
  logic signed [sobel_em_pkg::GRAD_W-1:0] gy_next;
  logic signed [sobel_em_pkg::GRAD_W-1:0] gx;
  logic signed [sobel_em_pkg::GRAD_W-1:0] gy;
  logic [sobel_em_pkg::SUM_W-1:0]         gx_abs;
  logic [sobel_em_pkg::SUM_W-1:0]         gy_abs;
  logic [sobel_em_pkg::GRAD_W-1:0]        l1;
  logic                                   s2_valid;
  sobel_em_pkg::pos_t                     s2_pos;

  // weighted row and column sums of the 3x3 window
  always_comb begin
    gx_neg = sobel_em_pkg::SUM_W'(win0.top) + (sobel_em_pkg::SUM_W'(win1.top) << 1)
           + sobel_em_pkg::SUM_W'(cur.top);
    gx_pos = sobel_em_pkg::SUM_W'(win0.bot) + (sobel_em_pkg::SUM_W'(win1.bot) << 1)
           + sobel_em_pkg::SUM_W'(cur.bot);
    gy_neg = sobel_em_pkg::SUM_W'(win0.top) + (sobel_em_pkg::SUM_W'(win0.mid) << 1)
           + sobel_em_pkg::SUM_W'(win0.bot);
    gy_pos = sobel_em_pkg::SUM_W'(cur.top) + (sobel_em_pkg::SUM_W'(cur.mid) << 1)
           + sobel_em_pkg::SUM_W'(cur.bot);
    gx_next = $signed(sobel_em_pkg::GRAD_W'(gx_pos)) - $signed(sobel_em_pkg::GRAD_W'(gx_neg));
    gy_next = $signed(sobel_em_pkg::GRAD_W'(gy_pos)) - $signed(sobel_em_pkg::GRAD_W'(gy_neg));
  end

  // window shift and gradient stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      win0     <= '0;
      win1     <= '0;
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= in_valid && in_pos.emit;
      if (in_valid) begin
        win0 <= win1;
        win1 <= cur;
      end
    end
  end

  // gradient stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      gx     <= gx_next;
      gy     <= gy_next;
      s2_pos <= in_pos;
    end
  end

  // l1 magnitude with saturation
  always_comb begin
    gx_abs = gx[sobel_em_pkg::GRAD_W-1] ? sobel_em_pkg::SUM_W'(-gx) : sobel_em_pkg::SUM_W'(gx);
    gy_abs = gy[sobel_em_pkg::GRAD_W-1] ? sobel_em_pkg::SUM_W'(-gy) : sobel_em_pkg::SUM_W'(gy);
    l1     = sobel_em_pkg::GRAD_W'(gx_abs) + sobel_em_pkg::GRAD_W'(gy_abs);
    if (l1 > sobel_em_pkg::GRAD_W'(sobel_em_pkg::MAG_MAX)) begin
      mag = sobel_em_pkg::MAG_MAX;
    end else begin
      mag = l1[sobel_em_pkg::PIX_W-1:0];
    end
  end

  assign out_valid = s2_valid;
  assign out_pos   = s2_pos;

endmodule

>>> rtl/sobel_edge_magnitude_core.sv
// 3x3 sobel edge detector, l1 magnitude saturated to 255
//
// pixel channel: 8-bit grayscale pixels in raster order, one transaction per
// pixel on pixel_valid / pixel_stall. result channel: one transaction per
// full 3x3 window, carrying magnitude, the window's top-left out_row/out_col
// and last_of_frame on the final window of the frame. the last two rows and
// columns of the output image produce no transaction.
// frame size comes from the apb registers image_width (0x0) and image_height
// (0x4), clamped to 3..4096; change them only while the block is idle.
// a result moves through the line store read stage, the gradient stage and
// the result register. throughput: one pixel per clock unless result_stall
// holds the pipeline, set by the single-port-per-side line store rams, which
// read a column as its pixel is taken and write it back as it leaves s1.
// reset: counters return to the frame origin, sizes go to 640 x 480 and the
// pipeline empties; line store contents are not cleared.
// when result_stall holds a shown result, the whole pipeline holds with it
// and pixel_stall is raised until the result is taken.
module sobel_edge_magnitude_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                pixel_valid,
  output logic                                pixel_stall,
  input  logic [7:0]                          pixel,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [7:0]                          magnitude,
  output logic [11:0]                         out_row,
  output logic [11:0]                         out_col,
  output logic                                last_of_frame,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sobel_em_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [sobel_em_pkg::APB_DATA_W-1:0] pwdata,
  output logic [sobel_em_pkg::APB_DATA_W-1:0] prdata,
  output logic                                pready
);

  logic [sobel_em_pkg::SIZE_W-1:0] width;
  logic [sobel_em_pkg::SIZE_W-1:0] height;
  logic [sobel_em_pkg::COL_W-1:0]  col_addr;
  sobel_em_pkg::pos_t              pos;
  logic                            en;
  logic                            accept;
  logic                            s1_valid;
  sobel_em_pkg::pixel_t            s1_pixel;
  sobel_em_pkg::pos_t              s1_pos;
  logic [sobel_em_pkg::COL_W-1:0]  s1_addr;
  logic                            line_wr;
  sobel_em_pkg::pixel_t            older_rd;
  sobel_em_pkg::pixel_t            newer_rd;
  sobel_em_pkg::column_t           cur;
  logic                            k_valid;
  sobel_em_pkg::pos_t              k_pos;
  logic [sobel_em_pkg::PIX_W-1:0]  k_mag;

  // pipeline moves whenever the output register is free or being emptied
  assign en          = !result_valid || !result_stall;
  assign pixel_stall = !en;
  assign accept      = pixel_valid && en;

  sobel_em_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .width   (width),
    .height  (height)
  );

  sobel_em_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .advance  (accept),
    .width    (width),
    .height   (height),
    .col_addr (col_addr),
    .pos      (pos)
  );

  // line store read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel <= pixel;
      s1_pos   <= pos;
      s1_addr  <= col_addr;
    end
  end

  // write back the shifted column as the pixel leaves the read stage
  assign line_wr = en && s1_valid;

  sobel_em_ram #(
    .WIDTH (sobel_em_pkg::PIX_W),
    .DEPTH (sobel_em_pkg::MAX_WIDTH)
  ) u_line_older (
    .clk   (clk),
    .we    (line_wr),
    .waddr (s1_addr),
    .wdata (newer_rd),
    .re    (accept),
    .raddr (col_addr),
    .rdata (older_rd)
  );

  sobel_em_ram #(
    .WIDTH (sobel_em_pkg::PIX_W),
    .DEPTH (sobel_em_pkg::MAX_WIDTH)
  ) u_line_newer (
    .clk   (clk),
    .we    (line_wr),
    .waddr (s1_addr),
    .wdata (s1_pixel),
    .re    (accept),
    .raddr (col_addr),
    .rdata (newer_rd)
  );

  // newest window column
  always_comb begin
    cur.top = older_rd;
    cur.mid = newer_rd;
    cur.bot = s1_pixel;
  end

  sobel_em_kernel u_kernel (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s1_valid),
    .in_pos    (s1_pos),
    .cur       (cur),
    .out_valid (k_valid),
    .out_pos   (k_pos),
    .mag       (k_mag)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= k_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && k_valid) begin
      magnitude     <= k_mag;
      out_row       <= k_pos.row;
      out_col       <= k_pos.col;
      last_of_frame <= k_pos.last;
    end
  end

endmodule

>>> rtl/sobel_em_chk.sv
`include "sobel_edge_magnitude_core_assert.svh"

module sobel_em_chk (
  input logic        clk,
  input logic        rst,
  input logic        pixel_stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic [7:0]  magnitude,
  input logic [11:0] out_row,
  input logic [11:0] out_col,
  input logic        last_of_frame
);

  // a stalled result keeps its payload
  `SEM_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(magnitude) && $stable(out_row) && $stable(out_col) && $stable(last_of_frame), "stalled result changed")

  // window origin never lands in the last two rows or columns
  `SEM_ASSERT_IMPL(a_coord_range, result_valid, (out_row <= 12'd4093) && (out_col <= 12'd4093), "result coordinate out of range")

  // input is held back only by a full, stalled result register
  `SEM_ASSERT_IMPL(a_stall_cause, pixel_stall, result_valid && result_stall, "pixel stalled without output backpressure")

endmodule

bind sobel_edge_magnitude_core sobel_em_chk u_chk (.*);

>>> verif/sobel_edge_magnitude_core_tb.sv
module sobel_edge_magnitude_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int TOTAL_PIXELS  = 400;
  localparam int SETTLE_CYCLES = 8;

  // one expected result transaction
  typedef struct {
    logic [7:0]  mag;
    logic [11:0] row;
    logic [11:0] col;
    logic        last;
  } sobel_result_t;

  // tracks frame position, line stores and window, and queues the magnitudes they produce
  class edge_map_tracker;
    logic [sobel_em_pkg::SIZE_W-1:0] width_reg;
    logic [sobel_em_pkg::SIZE_W-1:0] height_reg;
    sobel_em_pkg::pixel_t            older [sobel_em_pkg::MAX_WIDTH];
    sobel_em_pkg::pixel_t            newer [sobel_em_pkg::MAX_WIDTH];
    sobel_em_pkg::column_t           win_left;
    sobel_em_pkg::column_t           win_mid;
    int unsigned                     row_cnt;
    int unsigned                     col_cnt;
    sobel_result_t                   pending_magnitudes [$];
    int                              errors;

    function new();
      width_reg  = sobel_em_pkg::WIDTH_RESET;
      height_reg = sobel_em_pkg::HEIGHT_RESET;
      foreach (older[i]) begin
        older[i] = '0;
        newer[i] = '0;
      end
      win_left = '0;
      win_mid  = '0;
      row_cnt  = 0;
      col_cnt  = 0;
      errors   = 0;
    endfunction

    function int unsigned size_used(logic [sobel_em_pkg::SIZE_W-1:0] v, int unsigned hi);
      if (v < 3) return 3;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned width_used();
      return size_used(width_reg, sobel_em_pkg::MAX_WIDTH);
    endfunction

    function int unsigned height_used();
      return size_used(height_reg, sobel_em_pkg::MAX_HEIGHT);
    endfunction

    function bit at_origin();
      return (row_cnt == 0) && (col_cnt == 0);
    endfunction

    function int pending();
      return pending_magnitudes.size();
    endfunction

    function void write_reg(sobel_em_pkg::reg_idx_t idx, logic [31:0] val);
      if (idx == sobel_em_pkg::REG_IMAGE_WIDTH) width_reg = val[sobel_em_pkg::SIZE_W-1:0];
      else height_reg = val[sobel_em_pkg::SIZE_W-1:0];
    endfunction

    // one accepted pixel: shift line stores and window, queue a result for a full window
    function void take_pixel(sobel_em_pkg::pixel_t px);
      int unsigned           w;
      int unsigned           h;
      int unsigned           r;
      int unsigned           c;
      sobel_em_pkg::pixel_t  up2;
      sobel_em_pkg::pixel_t  up1;
      sobel_em_pkg::column_t cur;
      int                    gx;
      int                    gy;
      int                    sum;
      sobel_result_t         res;
      w   = width_used();
      h   = height_used();
      r   = row_cnt;
      c   = col_cnt;
      up2 = '0;
      up1 = '0;
      if (c < sobel_em_pkg::MAX_WIDTH) begin
        up2      = older[c];
        up1      = newer[c];
        older[c] = up1;
        newer[c] = px;
      end
      cur = '{top: up2, mid: up1, bot: px};
      if (r >= 2 && c >= 2) begin
        gx = -int'(win_left.top) - 2 * int'(win_mid.top) - int'(cur.top)
             + int'(win_left.bot) + 2 * int'(win_mid.bot) + int'(cur.bot);
        gy = -int'(win_left.top) - 2 * int'(win_left.mid) - int'(win_left.bot)
             + int'(cur.top) + 2 * int'(cur.mid) + int'(cur.bot);
        sum = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
        if (sum > int'(sobel_em_pkg::MAG_MAX)) sum = int'(sobel_em_pkg::MAG_MAX);
        res.mag  = sum[7:0];
        res.row  = 12'(r - 2);
        res.col  = 12'(c - 2);
        res.last = (r == h - 1) && (c == w - 1);
        pending_magnitudes.push_back(res);
      end
      win_left = win_mid;
      win_mid  = cur;
      // counters wrap on the next advance when at or past the limits
      if (c + 1 >= w) begin
        col_cnt = 0;
        row_cnt = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        col_cnt = c + 1;
        if (r >= h) row_cnt = 0;
      end
    endfunction

    // compare one accepted result with the oldest expectation
    function void check_magnitude(logic [7:0] mag, logic [11:0] row, logic [11:0] col,
                                  logic last);
      sobel_result_t exp_res;
      if (pending_magnitudes.size() == 0) begin
        $display("%0t: unexpected result mag %0d row %0d col %0d last %0d",
                 $time, mag, row, col, last);
        errors++;
        return;
      end
      exp_res = pending_magnitudes.pop_front();
      if (mag !== exp_res.mag) begin
        $display("%0t: magnitude expected %0d actual %0d", $time, exp_res.mag, mag);
        errors++;
      end
      if (row !== exp_res.row) begin
        $display("%0t: out_row expected %0d actual %0d", $time, exp_res.row, row);
        errors++;
      end
      if (col !== exp_res.col) begin
        $display("%0t: out_col expected %0d actual %0d", $time, exp_res.col, col);
        errors++;
      end
      if (last !== exp_res.last) begin
        $display("%0t: last_of_frame expected %0d actual %0d", $time, exp_res.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                pixel_valid = 1'b0;
  logic                                pixel_stall;
  logic [7:0]                          pixel = '0;
  logic                                result_valid;
  logic                                result_stall = 1'b0;
  logic [7:0]                          magnitude;
  logic [11:0]                         out_row;
  logic [11:0]                         out_col;
  logic                                last_of_frame;
  logic                                psel = 1'b0;
  logic                                penable = 1'b0;
  logic                                pwrite = 1'b0;
  logic [sobel_em_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [sobel_em_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [sobel_em_pkg::APB_DATA_W-1:0] prdata;
  logic                                pready;

  edge_map_tracker tracker = new();
  int              idle_level = 0;
  int              stall_left = 0;
  int              stall_len;
  int              cycle_count = 0;

  sobel_edge_magnitude_core dut (
    .clk           (clk),
    .rst           (rst),
    .pixel_valid   (pixel_valid),
    .pixel_stall   (pixel_stall),
    .pixel         (pixel),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .magnitude     (magnitude),
    .out_row       (out_row),
    .out_col       (out_col),
    .last_of_frame (last_of_frame),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #1 clk = ~clk;

  // idle length: none at level 0, short only at level 1, occasionally long at level 2
  function automatic int idle_cycles(int level);
    int pick;
    if (level == 0) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (level == 1) return 0;
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic sobel_em_pkg::pixel_t random_pixel();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return sobel_em_pkg::pixel_t'($urandom_range(0, 255));
    if (pick < 8) return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
    return sobel_em_pkg::pixel_t'($urandom_range(0, 15));
  endfunction

  // size register value, including clamped and masked cases
  function automatic logic [31:0] random_size();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return $urandom_range(0, 2);
    if (pick < 60) return $urandom_range(3, 8);
    if (pick < 85) return $urandom_range(9, 24);
    if (pick < 95) return $urandom_range(25, 64);
    return ($urandom & 32'hFFFF_E000) | $urandom_range(3, 8);
  endfunction

  // result side stall
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      result_stall <= 1'b1;
    end else begin
      stall_len = idle_cycles(idle_level);
      result_stall <= (stall_len > 0);
      stall_left = (stall_len > 0) ? stall_len - 1 : 0;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      tracker.check_magnitude(magnitude, out_row, out_col, last_of_frame);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sobel_edge_magnitude_core: mismatch");
      $finish;
    end
  end

  task automatic send_pixel(input sobel_em_pkg::pixel_t px);
    int gap;
    gap = idle_cycles(idle_level);
    if (gap > 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel       <= px;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    tracker.take_pixel(px);
  endtask

  // apb write: setup then access
  task automatic reg_write(input sobel_em_pkg::reg_idx_t idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= sobel_em_pkg::APB_ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.write_reg(idx, val);
  endtask

  // hold off the sender until every expected result is in and the pipe is empty
  task automatic wait_idle();
    pixel_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_sizes(input logic [31:0] w, input logic [31:0] h);
    wait_idle();
    reg_write(sobel_em_pkg::REG_IMAGE_WIDTH, w);
    reg_write(sobel_em_pkg::REG_IMAGE_HEIGHT, h);
  endtask

  // stream until the frame counters are back at the origin or the pixel budget is spent
  task automatic finish_frame(inout int sent);
    do begin
      send_pixel(random_pixel());
      sent++;
    end while (!tracker.at_origin() && sent < TOTAL_PIXELS);
  endtask

  initial begin
    int          sent;
    int          count;
    logic [31:0] new_w;
    logic [31:0] new_h;
    sent = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: 3x3 frames with a saturating edge, a flat field and a ramp
    set_sizes(32'd3, 32'd3);
    for (int i = 0; i < 9; i++) begin
      send_pixel((i >= 6) ? 8'hFF : 8'h00);
      sent++;
    end
    for (int i = 0; i < 9; i++) begin
      send_pixel(8'hFF);
      sent++;
    end
    for (int i = 0; i < 9; i++) begin
      send_pixel(sobel_em_pkg::pixel_t'(i));
      sent++;
    end

    // smallest frame, both sizes below the minimum
    idle_level = 1;
    set_sizes(32'd0, 32'd2);
    finish_frame(sent);

    // width above the limit: part of a first row of a tall frame
    set_sizes(32'h0000_1FFF, 32'd4096);
    repeat (40) begin
      send_pixel(random_pixel());
      sent++;
    end

    // narrow rows down the tall frame
    wait_idle();
    reg_write(sobel_em_pkg::REG_IMAGE_WIDTH, 32'd0);
    repeat (60) begin
      send_pixel(random_pixel());
      sent++;
    end

    // short frame, row counter already past it
    wait_idle();
    reg_write(sobel_em_pkg::REG_IMAGE_HEIGHT, 32'd5);

    // random frames, partial frames and size changes between them
    while (sent < TOTAL_PIXELS) begin
      new_w = random_size();
      new_h = random_size();
      if ($urandom_range(0, 9) != 0) begin
        wait_idle();
        // line stores only hold data for columns already streamed in this frame
        if (tracker.at_origin() ||
            tracker.size_used(new_w[sobel_em_pkg::SIZE_W-1:0], sobel_em_pkg::MAX_WIDTH)
            <= tracker.width_used()) begin
          reg_write(sobel_em_pkg::REG_IMAGE_WIDTH, new_w);
        end
        if ($urandom_range(0, 3) != 0) reg_write(sobel_em_pkg::REG_IMAGE_HEIGHT, new_h);
      end
      idle_level = $urandom_range(0, 2);
      if ($urandom_range(0, 3) != 0) begin
        finish_frame(sent);
      end else begin
        count = $urandom_range(1, 2 * tracker.width_used());
        repeat (count) begin
          send_pixel(random_pixel());
          sent++;
        end
      end
    end

    wait_idle();
    if (tracker.errors == 0) begin
      $display("sobel_edge_magnitude_core: match");
    end else begin
      $display("sobel_edge_magnitude_core: mismatch");
    end
    $finish;
  end

endmodule

>>> sobel_edge_magnitude_core.f
+incdir+rtl
rtl/sobel_em_pkg.sv
rtl/sobel_em_ram.sv
rtl/sobel_em_cfg.sv
rtl/sobel_em_scan.sv
rtl/sobel_em_kernel.sv
rtl/sobel_edge_magnitude_core.sv
rtl/sobel_em_chk.sv
verif/sobel_edge_magnitude_core_tb.sv
